>>> src/gsp_pkg.sv
`default_nettype none

package gsp_pkg;

	// Sequencer phases
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_POLL,
		PH_CONF,
		PH_GAP
	} phase_t;

	// Limits of the poll sequence
	localparam logic [2:0] MaxTries   = 3'd5;
	localparam logic [4:0] ExtraBytes = 5'd12;
	localparam logic [4:0] PollLen    = 5'd9;

	// Reconfiguration strings, in the order sent
	localparam logic [2:0] SEL_ENTER    = 3'd0;
	localparam logic [2:0] SEL_MODE     = 3'd1;
	localparam logic [2:0] SEL_RUMBLE   = 3'd2;
	localparam logic [2:0] SEL_PRESSURE = 3'd3;
	localparam logic [2:0] SEL_EXIT     = 3'd4;
	localparam logic [2:0] SEL_POLL     = 3'd5;

	// Configuration register indexes
	localparam logic CFG_RUMBLE   = 1'b0;
	localparam logic CFG_PRESSURE = 1'b1;

	// Protocol bytes
	localparam logic [7:0] FRAME_HEAD = 8'h01;
	localparam logic [7:0] CMD_POLL   = 8'h42;
	localparam logic [7:0] MODE_LARGE = 8'h79;
	localparam logic [3:0] MODE_OK    = 4'h7;
	localparam logic [7:0] IDLE_LINE  = 8'hFF;

	typedef struct packed {
		logic       cmd_bit;
		logic       select_active;
		logic       byte_done;
		logic [4:0] byte_index;
		logic [7:0] byte_value;
		logic       poll_done;
		logic       poll_ok;
		logic       busy;
	} step_res_t;

	typedef struct packed {
		logic       start;
		logic       cap_lo;
		logic       cap_hi;
		logic       finish;
		logic [7:0] data;
	} btn_ctl_t;

	typedef struct packed {
		logic [15:0] held;
		logic [15:0] pressed;
		logic [15:0] released;
	} btn_masks_t;

	// Body of a reconfiguration string; bytes past the table read as zero.
	function automatic logic [7:0] conf_byte(input logic [2:0] sel, input logic [4:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (sel)
			SEL_ENTER: begin
				case (idx)
					5'd0: b = 8'h01;
					5'd1: b = 8'h43;
					5'd3: b = 8'h01;
					default: b = 8'h00;
				endcase
			end
			SEL_MODE: begin
				case (idx)
					5'd0: b = 8'h01;
					5'd1: b = 8'h44;
					5'd3: b = 8'h01;
					5'd4: b = 8'h03;
					default: b = 8'h00;
				endcase
			end
			SEL_RUMBLE: begin
				case (idx)
					5'd0: b = 8'h01;
					5'd1: b = 8'h4D;
					5'd4: b = 8'h01;
					default: b = 8'h00;
				endcase
			end
			SEL_PRESSURE: begin
				case (idx)
					5'd0: b = 8'h01;
					5'd1: b = 8'h4F;
					5'd3: b = 8'hFF;
					5'd4: b = 8'hFF;
					5'd5: b = 8'h03;
					default: b = 8'h00;
				endcase
			end
			default: begin
				case (idx)
					5'd0: b = 8'h01;
					5'd1: b = 8'h43;
					5'd4, 5'd5, 5'd6, 5'd7, 5'd8: b = 8'h5A;
					default: b = 8'h00;
				endcase
			end
		endcase
		return b;
	endfunction

	function automatic logic [4:0] conf_len(input logic [2:0] sel);
		logic [4:0] n;
		case (sel)
			SEL_ENTER, SEL_RUMBLE: n = 5'd5;
			default:               n = 5'd9;
		endcase
		return n;
	endfunction

	// Skip the optional strings that are switched off.
	function automatic logic [2:0] next_string(input logic [2:0] s, input logic rumble,
		input logic pressure);
		logic [2:0] n;
		n = s + 3'd1;
		if (n == SEL_RUMBLE && !rumble)
			n = SEL_PRESSURE;
		if (n == SEL_PRESSURE && !pressure)
			n = SEL_EXIT;
		return n;
	endfunction

	// Large motor speed: zero stays off, else 64 + v*191/255.
	// The divide by 255 is (x + (x >> 8) + 1) >> 8, exact for x below 65535.
	function automatic logic [7:0] motor_map(input logic [7:0] v);
		logic [16:0] x;
		logic [16:0] q;
		x = 17'(v) * 17'd191;
		q = (x + (x >> 8) + 17'd1) >> 8;
		return (v == 8'd0) ? 8'd0 : 8'(q) + 8'd64;
	endfunction

endpackage

`default_nettype wire

>>> src/gsp_btn.sv
`default_nettype none

module gsp_btn (
	input  wire                  clk,
	input  wire                  arst_n,
	input  gsp_pkg::btn_ctl_t    ctl,
	output gsp_pkg::btn_masks_t  masks
);
	import gsp_pkg::*;

	logic [15:0] raw_q;
	logic [15:0] prev_q;
	logic [15:0] changed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q  <= 16'hFFFF;
			prev_q <= 16'hFFFF;
		end else begin
			if (ctl.start)
				prev_q <= raw_q;
			if (ctl.cap_lo)
				raw_q[7:0] <= ctl.data;
			if (ctl.cap_hi)
				raw_q[15:8] <= ctl.data;
		end
	end

	// Buttons are active low on the wire
	always_comb begin
		changed = raw_q ^ prev_q;
		masks   = '0;
		if (ctl.finish) begin
			masks.held     = ~raw_q;
			masks.pressed  = changed & ~raw_q;
			masks.released = changed & ~prev_q;
		end
	end

endmodule

`default_nettype wire

>>> src/gsp_seq.sv
`default_nettype none

module gsp_seq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  wire                 op,
	input  wire                 small_motor,
	input  wire  [7:0]          large_motor,
	input  wire                 data_bit,
	input  wire                 rumble_en,
	input  wire                 pressure_en,
	output gsp_pkg::step_res_t  res,
	output gsp_pkg::btn_ctl_t   ctl
);
	import gsp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  sel_q, sel_d;
	logic [4:0]  byte_q, byte_d;
	logic [2:0]  bit_q, bit_d;
	logic [7:0]  tx_q, tx_d;
	logic [7:0]  rx_q, rx_d;
	logic [2:0]  retry_q, retry_d;
	logic [7:0]  mode_q, mode_d;
	logic [8:0]  motor_q, motor_d;

	logic [2:0]  ci;
	logic [7:0]  rx_sh;
	logic [4:0]  byte_inc;
	logic [4:0]  len;
	logic [7:0]  mode_new;
	logic [2:0]  nsel;
	logic [7:0]  next_tx;
	logic        finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sel_q   <= SEL_ENTER;
			byte_q  <= '0;
			bit_q   <= '0;
			tx_q    <= IDLE_LINE;
			rx_q    <= '0;
			retry_q <= '0;
			mode_q  <= '0;
			motor_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			sel_q   <= sel_d;
			byte_q  <= byte_d;
			bit_q   <= bit_d;
			tx_q    <= tx_d;
			rx_q    <= rx_d;
			retry_q <= retry_d;
			mode_q  <= mode_d;
			motor_q <= motor_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		sel_d    = sel_q;
		byte_d   = byte_q;
		bit_d    = bit_q;
		tx_d     = tx_q;
		rx_d     = rx_q;
		retry_d  = retry_q;
		mode_d   = mode_q;
		motor_d  = motor_q;
		ci       = (sel_q > SEL_EXIT) ? SEL_EXIT : sel_q;
		rx_sh    = {data_bit, rx_q[7:1]};
		byte_inc = byte_q + 5'd1;
		mode_new = mode_q;
		len      = conf_len(ci);
		nsel     = next_string(ci, rumble_en, pressure_en);
		finish   = 1'b0;
		res      = '0;
		ctl      = '0;
		ctl.data = rx_sh;

		// Next byte of the frame in flight
		if (phase_q == PH_CONF) begin
			next_tx = (byte_inc < 5'd9) ? conf_byte(ci, byte_inc) : 8'h00;
		end else begin
			case (byte_inc)
				5'd1:    next_tx = CMD_POLL;
				5'd3:    next_tx = {7'd0, motor_q[0]};
				5'd4:    next_tx = motor_q[8:1];
				default: next_tx = 8'h00;
			endcase
		end

		if (!op) begin
			if (phase_q == PH_IDLE) begin
				motor_d   = {motor_map(large_motor), small_motor};
				retry_d   = '0;
				phase_d   = PH_POLL;
				byte_d    = '0;
				bit_d     = '0;
				rx_d      = '0;
				tx_d      = FRAME_HEAD;
				ctl.start = adv;
			end
		end else if (phase_q == PH_GAP) begin
			phase_d = (sel_q >= SEL_POLL) ? PH_POLL : PH_CONF;
			byte_d  = '0;
			bit_d   = '0;
			rx_d    = '0;
			tx_d    = FRAME_HEAD;
		end else if (phase_q == PH_POLL || phase_q == PH_CONF) begin
			rx_d  = rx_sh;
			tx_d  = {1'b1, tx_q[7:1]};
			bit_d = bit_q + 3'd1;
			if (bit_q == 3'd7) begin
				rx_d = '0;
				if (phase_q == PH_POLL) begin
					res.byte_done  = 1'b1;
					res.byte_index = byte_q;
					res.byte_value = rx_sh;
					if (byte_q == 5'd1)
						mode_new = rx_sh;
					ctl.cap_lo = adv && (byte_q == 5'd3);
					ctl.cap_hi = adv && (byte_q == 5'd4);
					len = (mode_new == MODE_LARGE) ? PollLen + ExtraBytes : PollLen;
				end
				mode_d = mode_new;
				if (byte_inc < len) begin
					byte_d = byte_inc;
					tx_d   = next_tx;
				end else begin
					byte_d = '0;
					tx_d   = IDLE_LINE;
					if (phase_q == PH_POLL) begin
						if (mode_new[7:4] == MODE_OK) begin
							finish = 1'b1;
						end else begin
							if (retry_q != 3'd7)
								retry_d = retry_q + 3'd1;
							sel_d   = SEL_ENTER;
							phase_d = PH_GAP;
						end
					end else if (nsel <= SEL_EXIT) begin
						sel_d   = nsel;
						phase_d = PH_GAP;
					end else if (retry_q < MaxTries) begin
						sel_d   = SEL_POLL;
						phase_d = PH_GAP;
					end else begin
						finish = 1'b1;
					end
					if (finish) begin
						phase_d       = PH_IDLE;
						sel_d         = SEL_ENTER;
						res.poll_done = 1'b1;
						res.poll_ok   = (mode_new[7:4] == MODE_OK);
						ctl.finish    = 1'b1;
					end
				end
			end
		end

		res.select_active = (phase_d == PH_POLL) || (phase_d == PH_CONF);
		res.cmd_bit       = res.select_active ? tx_d[0] : 1'b1;
		res.busy          = (phase_d != PH_IDLE);
	end

endmodule

`default_nettype wire

>>> src/gamepad_serial_poller.sv
`default_nettype none

// Channel   Handshake               Payload
// in        in_valid / in_stall     op, small_motor, large_motor, data_bit
// out       out_valid / out_stall   cmd_bit .. busy_res (one result per input beat)
// cfg       cfg_we                  cfg_index, cfg_data (no read-back)
//
// Every input beat yields exactly one result beat, through the input register and
// then the result register; a beat may be taken every cycle when in_stall is low.
// The per-tick step is one pass of the sequencer logic between the two registers.
// Reset (arst_n low) clears the sequencer, the handshake state and the config;
// the button words reset to all released.
// in_stall rises only while the input register holds a beat that the result
// register cannot take because the result it holds is itself stalled.
module gamepad_serial_poller (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         in_valid,
	output logic        in_stall,
	input  wire         op,
	input  wire         small_motor,
	input  wire  [7:0]  large_motor,
	input  wire         data_bit,

	output logic        out_valid,
	input  wire         out_stall,
	output logic        cmd_bit,
	output logic        select_active,
	output logic        byte_done,
	output logic [4:0]  byte_index,
	output logic [7:0]  byte_value,
	output logic        poll_done,
	output logic        poll_ok,
	output logic [15:0] held_mask,
	output logic [15:0] pressed_mask,
	output logic [15:0] released_mask,
	output logic        busy_res,

	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire         cfg_data
);
	import gsp_pkg::*;

	// Input register
	logic        valid_s1;
	logic        op_s1;
	logic        small_s1;
	logic [7:0]  large_s1;
	logic        dbit_s1;

	// Configuration
	logic        rumble_q;
	logic        pressure_q;

	logic        adv;
	logic        in_take;
	step_res_t   step;
	btn_ctl_t    btn_ctl;
	btn_masks_t  masks;

	// Advance the held beat whenever the result register is empty or draining
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input register: hold while stalled
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1    <= op;
			small_s1 <= small_motor;
			large_s1 <= large_motor;
			dbit_s1  <= data_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rumble_q   <= 1'b0;
			pressure_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RUMBLE:   rumble_q   <= cfg_data;
				CFG_PRESSURE: pressure_q <= cfg_data;
				default:      rumble_q   <= rumble_q;
			endcase
		end
	end

	gsp_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.op          (op_s1),
		.small_motor (small_s1),
		.large_motor (large_s1),
		.data_bit    (dbit_s1),
		.rumble_en   (rumble_q),
		.pressure_en (pressure_q),
		.res         (step),
		.ctl         (btn_ctl)
	);

	gsp_btn u_btn (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (btn_ctl),
		.masks  (masks)
	);

	// Result register: load on advance, drop the valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_bit       <= step.cmd_bit;
			select_active <= step.select_active;
			byte_done     <= step.byte_done;
			byte_index    <= step.byte_index;
			byte_value    <= step.byte_value;
			poll_done     <= step.poll_done;
			poll_ok       <= step.poll_ok;
			busy_res      <= step.busy;
			held_mask     <= masks.held;
			pressed_mask  <= masks.pressed;
			released_mask <= masks.released;
		end
	end

`ifndef SYNTH
	// A finished poll leaves the sequencer idle with attention released
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && poll_done |-> !busy_res && !select_active)
		else $error("poll finished while sequencer still busy");

	// Reply byte positions stay inside the longest frame
	a_byte_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_done |-> byte_index < PollLen + ExtraBytes)
		else $error("reply byte reported past the end of a frame");

	// Command line idles high whenever attention is released
	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !select_active |-> cmd_bit)
		else $error("command line low with attention released");

	// Button masks and the ok flag appear only on the finishing beat
	a_masks_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !poll_done |-> !poll_ok && held_mask == 16'd0
			&& pressed_mask == 16'd0 && released_mask == 16'd0)
		else $error("poll result fields set outside the finishing beat");
`endif

endmodule

`default_nettype wire

>>> tb/gamepad_serial_poller_tb.sv
module gamepad_serial_poller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gsp_pkg::*;

	// Item opcodes on the op field
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam int CYCLE_LIMIT  = 400000; // several times the slowest legal run
	localparam int HOLD_CYCLES  = 90;     // long receiver hold-off to fill the block
	localparam int RANDOM_SHARE = 60;     // beats of random requests in the last phase
	localparam int PRINT_CAP    = 40;

	// One input beat
	typedef struct packed {
		logic       op;
		logic       small_on;
		logic [7:0] speed;
		logic       dbit;
	} tick_item_t;

	// Predicted view of one result beat
	typedef struct packed {
		logic        cmd_bit;
		logic        select_active;
		logic        byte_done;
		logic [4:0]  byte_index;
		logic [7:0]  byte_value;
		logic        poll_done;
		logic        poll_ok;
		logic [15:0] held;
		logic [15:0] pressed;
		logic [15:0] released;
		logic        busy;
	} poll_view_t;

	// Poller state as the predictor tracks it
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  sel;
		logic [4:0]  byte_cnt;
		logic [2:0]  bit_cnt;
		logic [7:0]  tx_sr;
		logic [7:0]  rx_sr;
		logic [2:0]  tries;
		logic [7:0]  mode;
		logic [15:0] buttons;
		logic [15:0] prev_buttons;
		logic [8:0]  motors;
	} poll_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic        small_motor = 1'b0;
	logic [7:0]  large_motor = 8'd0;
	logic        data_bit = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        cmd_bit;
	logic        select_active;
	logic        byte_done;
	logic [4:0]  byte_index;
	logic [7:0]  byte_value;
	logic        poll_done;
	logic        poll_ok;
	logic [15:0] held_mask;
	logic [15:0] pressed_mask;
	logic [15:0] released_mask;
	logic        busy_res;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;

	gamepad_serial_poller uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.small_motor(small_motor),
		.large_motor(large_motor),
		.data_bit(data_bit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd_bit(cmd_bit),
		.select_active(select_active),
		.byte_done(byte_done),
		.byte_index(byte_index),
		.byte_value(byte_value),
		.poll_done(poll_done),
		.poll_ok(poll_ok),
		.held_mask(held_mask),
		.pressed_mask(pressed_mask),
		.released_mask(released_mask),
		.busy_res(busy_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the configuration registers
	logic rumble_on = 1'b0;
	logic pressure_on = 1'b0;

	// The stimulus builder runs its own copy of the poller so that it can aim
	// reply bits at the right byte; the checker copy advances on accepted beats.
	poll_state_t gen_st;
	poll_state_t chk_st;

	tick_item_t pending_ticks[$];
	poll_view_t expected_steps[$];

	int gen_items = 0;
	int beats_in = 0;
	int results_seen = 0;
	int mismatches = 0;
	int polls_done = 0;
	int polls_ok = 0;
	int reply_bytes = 0;
	int cycle_count = 0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_armed = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	logic beat_taken = 1'b0;
	tick_item_t next_tick;
	tick_item_t taken_tick;
	poll_view_t want_view;
	poll_view_t got_view;

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// Reconfiguration string bodies, byte 0 in the low bits
	function automatic logic [71:0] string_body(input logic [2:0] s);
		case (s)
			SEL_ENTER:    return 72'h00_00_00_00_00_01_00_43_01;
			SEL_MODE:     return 72'h00_00_00_00_03_01_00_44_01;
			SEL_RUMBLE:   return 72'h00_00_00_00_01_00_00_4D_01;
			SEL_PRESSURE: return 72'h00_00_00_03_FF_FF_00_4F_01;
			default:      return 72'h5A_5A_5A_5A_5A_00_00_43_01;
		endcase
	endfunction

	function automatic int unsigned string_bytes(input logic [2:0] s);
		return (s == SEL_ENTER || s == SEL_RUMBLE) ? 5 : 9;
	endfunction

	// Clamp a string selector onto the table
	function automatic logic [2:0] clamp_sel(input logic [2:0] s);
		return (s > SEL_EXIT) ? SEL_EXIT : s;
	endfunction

	// Step to the next string, skipping the optional ones that are switched off
	function automatic logic [2:0] following_string(input logic [2:0] s, input logic rumble,
		input logic pressure);
		logic [2:0] n;
		n = s + 3'd1;
		if (n == SEL_RUMBLE && !rumble)
			n = SEL_PRESSURE;
		if (n == SEL_PRESSURE && !pressure)
			n = SEL_EXIT;
		return n;
	endfunction

	// Command byte at position idx of the frame now on the wire
	function automatic logic [7:0] frame_byte(input poll_state_t st, input logic [4:0] idx);
		logic [71:0] body;
		body = string_body(clamp_sel(st.sel));
		if (st.phase == PH_CONF)
			return (idx < 5'd9) ? body[idx*8 +: 8] : 8'h00;
		case (idx)
			5'd0:    return FRAME_HEAD;
			5'd1:    return CMD_POLL;
			5'd3:    return {7'd0, st.motors[0]};
			5'd4:    return st.motors[8:1];
			default: return 8'h00;
		endcase
	endfunction

	task automatic poll_clear(output poll_state_t st);
		st.phase = PH_IDLE;
		st.sel = SEL_ENTER;
		st.byte_cnt = 5'd0;
		st.bit_cnt = 3'd0;
		st.tx_sr = IDLE_LINE;
		st.rx_sr = 8'h00;
		st.tries = 3'd0;
		st.mode = 8'h00;
		st.buttons = 16'hFFFF;
		st.prev_buttons = 16'hFFFF;
		st.motors = 9'd0;
	endtask

	// Advance the poller by one beat and give the line levels and events it shows
	task automatic poll_advance(inout poll_state_t st, input tick_item_t it,
		input logic rumble, input logic pressure, output poll_view_t r);
		logic [7:0] got_byte;
		logic [2:0] nxt;
		logic [15:0] changed;
		int unsigned frame_len;
		int unsigned code;
		logic finish;
		r = '0;
		finish = 1'b0;
		if (it.op == OP_START) begin
			// a start while busy is dropped
			if (st.phase == PH_IDLE) begin
				code = (it.speed != 8'd0) ? 64 + (32'(it.speed) * 191) / 255 : 0;
				st.motors = {code[7:0], it.small_on};
				st.prev_buttons = st.buttons;
				st.tries = 3'd0;
				st.phase = PH_POLL;
				st.byte_cnt = 5'd0;
				st.bit_cnt = 3'd0;
				st.rx_sr = 8'h00;
				st.tx_sr = frame_byte(st, 5'd0);
			end
		end else if (st.phase == PH_GAP) begin
			// re-assert attention; this beat's data bit is ignored
			st.phase = (st.sel >= SEL_POLL) ? PH_POLL : PH_CONF;
			st.byte_cnt = 5'd0;
			st.bit_cnt = 3'd0;
			st.rx_sr = 8'h00;
			st.tx_sr = frame_byte(st, 5'd0);
		end else if (st.phase == PH_POLL || st.phase == PH_CONF) begin
			st.rx_sr = {it.dbit, st.rx_sr[7:1]};
			st.tx_sr = {1'b1, st.tx_sr[7:1]};
			st.bit_cnt = st.bit_cnt + 3'd1;
			if (st.bit_cnt == 3'd0) begin
				got_byte = st.rx_sr;
				st.rx_sr = 8'h00;
				if (st.phase == PH_POLL) begin
					r.byte_done = 1'b1;
					r.byte_index = st.byte_cnt;
					r.byte_value = got_byte;
					if (st.byte_cnt == 5'd1)
						st.mode = got_byte;
					if (st.byte_cnt == 5'd3)
						st.buttons[7:0] = got_byte;
					if (st.byte_cnt == 5'd4)
						st.buttons[15:8] = got_byte;
					frame_len = 32'(PollLen)
						+ ((st.mode == MODE_LARGE) ? 32'(ExtraBytes) : 32'd0);
				end else begin
					frame_len = string_bytes(clamp_sel(st.sel));
				end
				st.byte_cnt = st.byte_cnt + 5'd1;
				if (st.byte_cnt < frame_len) begin
					st.tx_sr = frame_byte(st, st.byte_cnt);
				end else begin
					st.byte_cnt = 5'd0;
					st.tx_sr = IDLE_LINE;
					if (st.phase == PH_POLL) begin
						if (st.mode[7:4] == MODE_OK) begin
							finish = 1'b1;
						end else begin
							if (st.tries < 3'd7)
								st.tries = st.tries + 3'd1;
							st.sel = SEL_ENTER;
							st.phase = PH_GAP;
						end
					end else begin
						nxt = following_string(clamp_sel(st.sel), rumble, pressure);
						if (nxt <= SEL_EXIT) begin
							st.sel = nxt;
							st.phase = PH_GAP;
						end else if (st.tries < MaxTries) begin
							st.sel = SEL_POLL;
							st.phase = PH_GAP;
						end else begin
							finish = 1'b1;
						end
					end
					if (finish) begin
						changed = st.buttons ^ st.prev_buttons;
						st.phase = PH_IDLE;
						st.sel = SEL_ENTER;
						r.poll_done = 1'b1;
						r.poll_ok = (st.mode[7:4] == MODE_OK);
						r.held = ~st.buttons;
						r.pressed = changed & ~st.buttons;
						r.released = changed & ~st.prev_buttons;
					end
				end
			end
		end
		r.select_active = (st.phase == PH_POLL || st.phase == PH_CONF);
		r.cmd_bit = r.select_active ? st.tx_sr[0] : 1'b1;
		r.busy = (st.phase != PH_IDLE);
	endtask

	// ---------------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------------

	task automatic push_item(input tick_item_t it);
		poll_view_t scratch;
		pending_ticks.push_back(it);
		poll_advance(gen_st, it, rumble_on, pressure_on, scratch);
		gen_items++;
	endtask

	// Mode byte whose upper nibble is not the good one
	function automatic logic [7:0] bad_mode();
		logic [7:0] m;
		m = 8'($urandom);
		if ($urandom_range(0, 3) == 0)
			m = 8'h41;
		if (m[7:4] == MODE_OK)
			m[7:4] = 4'h4;
		return m;
	endfunction

	function automatic logic [7:0] good_mode();
		int unsigned pick;
		logic [3:0] lo;
		pick = $urandom_range(0, 99);
		lo = 4'($urandom);
		if (pick < 60)
			return 8'h73;
		if (pick < 80)
			return MODE_LARGE;
		return {MODE_OK, lo};
	endfunction

	// Queue a start and every tick the whole poll request needs. The first
	// 'fails' poll frames answer with a bad mode; the last frame carries btn_word.
	task automatic queue_poll(input logic small_on, input logic [7:0] speed,
		input logic [7:0] last_mode, input logic [15:0] btn_word, input int fails,
		input int stray_pct);
		logic [20:0][7:0] reply;
		tick_item_t it;
		int frame_no;
		frame_no = 0;
		reply = '0;
		it.op = OP_START;
		it.small_on = small_on;
		it.speed = speed;
		it.dbit = 1'($urandom);
		push_item(it);
		while (gen_st.phase != PH_IDLE) begin
			if (gen_st.phase == PH_POLL && gen_st.byte_cnt == 5'd0 && gen_st.bit_cnt == 3'd0) begin
				for (int i = 0; i < 21; i++)
					reply[i] = 8'($urandom);
				if (frame_no < fails) begin
					reply[1] = bad_mode();
				end else begin
					reply[1] = last_mode;
					reply[3] = btn_word[7:0];
					reply[4] = btn_word[15:8];
				end
				frame_no++;
			end
			// a start in the middle of a sequence must be ignored
			if (stray_pct != 0 && $urandom_range(0, 99) < stray_pct) begin
				it.op = OP_START;
				it.small_on = 1'($urandom);
				it.speed = 8'($urandom);
				it.dbit = 1'($urandom);
				push_item(it);
			end
			it.op = OP_TICK;
			it.small_on = 1'($urandom);
			it.speed = 8'($urandom);
			it.dbit = (gen_st.phase == PH_POLL) ? reply[gen_st.byte_cnt][gen_st.bit_cnt]
				: 1'($urandom);
			push_item(it);
		end
	endtask

	// Ticks while idle do nothing; sprinkle a few between requests
	task automatic queue_idle_ticks(input int n);
		tick_item_t it;
		for (int i = 0; i < n; i++) begin
			it.op = OP_TICK;
			it.small_on = 1'($urandom);
			it.speed = 8'($urandom);
			it.dbit = 1'($urandom);
			push_item(it);
		end
	endtask

	// Random requests until about 'share' beats are queued. The first one
	// answers well at once; later ones may retry.
	task automatic queue_random(input int share);
		int first_item;
		int pick;
		int fails;
		logic [15:0] btn;
		first_item = gen_items;
		fails = 0;
		while (gen_items - first_item < share) begin
			queue_idle_ticks($urandom_range(0, 2));
			pick = $urandom_range(0, 99);
			btn = (pick < 10) ? 16'h0000 : (pick < 20) ? 16'hFFFF : 16'($urandom);
			queue_poll(1'($urandom), 8'($urandom), good_mode(), btn, fails, 1);
			pick = $urandom_range(0, 99);
			fails = (pick < 60) ? 0 : (pick < 85) ? 1 : (pick < 95) ? 2 : 3;
		end
	endtask

	task automatic write_reg(input logic idx, input logic val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_RUMBLE)
			rumble_on = val;
		else
			pressure_on = val;
	endtask

	// Hold until every queued beat has gone in and every result come back
	task automatic drain();
		while (pending_ticks.size() != 0 || in_valid || expected_steps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at result %0d: %s", results_seen, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
	endtask

	// ---------------------------------------------------------------------
	// Driver: present the next beat at the falling edge; hold a stalled beat
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || beat_taken) begin
			if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				next_tick = pending_ticks.pop_front();
				in_valid <= 1'b1;
				op <= next_tick.op;
				small_motor <= next_tick.small_on;
				large_motor <= next_tick.speed;
				data_bit <= next_tick.dbit;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when armed so that the
	// block fills up and has to stall its input
	always @(negedge clk) begin
		if (hold_armed && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Monitor: predict on every accepted input beat, compare every result beat
	always @(posedge clk) begin
		if (arst_n) begin
			beat_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				taken_tick.op = op;
				taken_tick.small_on = small_motor;
				taken_tick.speed = large_motor;
				taken_tick.dbit = data_bit;
				poll_advance(chk_st, taken_tick, rumble_on, pressure_on, want_view);
				expected_steps.push_back(want_view);
				beats_in++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_steps.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want_view = expected_steps.pop_front();
					got_view.cmd_bit = cmd_bit;
					got_view.select_active = select_active;
					got_view.byte_done = byte_done;
					got_view.byte_index = byte_index;
					got_view.byte_value = byte_value;
					got_view.poll_done = poll_done;
					got_view.poll_ok = poll_ok;
					got_view.held = held_mask;
					got_view.pressed = pressed_mask;
					got_view.released = released_mask;
					got_view.busy = busy_res;
					check_field("cmd_bit", 16'(got_view.cmd_bit), 16'(want_view.cmd_bit));
					check_field("select_active", 16'(got_view.select_active),
						16'(want_view.select_active));
					check_field("byte_done", 16'(got_view.byte_done),
						16'(want_view.byte_done));
					check_field("byte_index", 16'(got_view.byte_index),
						16'(want_view.byte_index));
					check_field("byte_value", 16'(got_view.byte_value),
						16'(want_view.byte_value));
					check_field("poll_done", 16'(got_view.poll_done),
						16'(want_view.poll_done));
					check_field("poll_ok", 16'(got_view.poll_ok), 16'(want_view.poll_ok));
					check_field("held_mask", got_view.held, want_view.held);
					check_field("pressed_mask", got_view.pressed, want_view.pressed);
					check_field("released_mask", got_view.released, want_view.released);
					check_field("busy_res", 16'(got_view.busy), 16'(want_view.busy));
					if (want_view.byte_done)
						reply_bytes++;
					if (want_view.poll_done) begin
						polls_done++;
						if (want_view.poll_ok)
							polls_ok++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_steps.size());
			$display("gamepad_serial_poller_tb NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Run sequence
	// ---------------------------------------------------------------------
	initial begin
		poll_clear(gen_st);
		poll_clear(chk_st);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings written back explicitly, sender and
		// receiver both idling, receiver the slower of the two
		tx_idle_pct = 38;
		rx_idle_pct = 77;
		write_reg(CFG_RUMBLE, 1'b0);
		write_reg(CFG_PRESSURE, 1'b0);
		@(posedge clk);
		queue_idle_ticks(1);
		// full speed, small motor on, every button pressed
		queue_poll(1'b1, 8'd255, 8'h73, 16'h0000, 0, 0);
		// motors off, one retry through the short string set, then a long
		// reply with every button released again
		queue_poll(1'b0, 8'd0, MODE_LARGE, 16'hFFFF, 1, 4);
		queue_idle_ticks(2);
		drain();

		// Every optional string on; swap the idling so the sender is the slow side
		tx_idle_pct = 77;
		rx_idle_pct = 38;
		write_reg(CFG_RUMBLE, 1'b1);
		write_reg(CFG_PRESSURE, 1'b1);
		@(posedge clk);
		// lowest nonzero speed, one retry through the full string set
		queue_poll(1'b1, 8'd1, 8'h7F, 16'h5AA5, 1, 0);
		drain();

		// Pressure string only, no idling, and the long receiver hold-off
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(CFG_RUMBLE, 1'b0);
		@(posedge clk);
		hold_armed = 1'b1;
		queue_poll(1'b0, 8'd128, 8'h70, 16'hA55A, 0, 2);
		queue_random(RANDOM_SHARE);
		drain();

		$display("covered %0d beats, %0d reply bytes, %0d poll requests (%0d ok)",
			beats_in, reply_bytes, polls_done, polls_ok);
		$display("three register settings, idling both ways and none, one long hold-off");
		if (mismatches == 0) begin
			$display("gamepad_serial_poller_tb OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("gamepad_serial_poller_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> sim.f
src/gsp_pkg.sv
src/gsp_btn.sv
src/gsp_seq.sv
src/gamepad_serial_poller.sv
tb/gamepad_serial_poller_tb.sv
